[rtl/bdsc_pkg.sv]
package bdsc_pkg;

	localparam int STORE_BANK_DEPTH_DEF = 8;
	localparam int STACK_DEPTH_DEF = 3;

	localparam logic [3:0] MISC_LDY   = 4'h0;
	localparam logic [3:0] MISC_BANK  = 4'h1;
	localparam logic [3:0] MISC_BR5   = 4'h2;
	localparam logic [3:0] MISC_RET   = 4'h3;
	localparam logic [3:0] MISC_STX   = 4'h4;
	localparam logic [3:0] MISC_LDX   = 4'h5;
	localparam logic [3:0] MISC_STY   = 4'h6;
	localparam logic [3:0] MISC_DISP  = 4'h7;
	localparam logic [3:0] MISC_DEC   = 4'h8;
	localparam logic [3:0] MISC_HEX   = 4'h9;
	localparam logic [3:0] MISC_BANKR = 4'hA;

	localparam logic [3:0] MASK_FLAG = 4'hC;
	localparam logic [3:0] MASK_MISC = 4'hE;

	typedef struct packed {
		logic [3:0] lo;
		logic [3:0] hi;
	} range_t;

	function automatic range_t mask_range(input logic [3:0] m);
		range_t r;
		case (m)
			4'h0: r = '{4'd12, 4'd12};
			4'h1: r = '{4'd0, 4'd15};
			4'h2: r = '{4'd2, 4'd12};
			4'h3: r = '{4'd0, 4'd12};
			4'h4: r = '{4'd2, 4'd2};
			4'h5: r = '{4'd0, 4'd1};
			4'h6: r = '{4'd0, 4'd0};
			4'h7: r = '{4'd0, 4'd13};
			4'h8: r = '{4'd14, 4'd14};
			4'h9: r = '{4'd13, 4'd15};
			4'hA: r = '{4'd14, 4'd15};
			4'hD: r = '{4'd13, 4'd13};
			4'hF: r = '{4'd15, 4'd15};
			default: r = '{4'd0, 4'd0};
		endcase
		return r;
	endfunction

endpackage

[rtl/bdsc_stream_if.sv]
interface bdsc_stream_if #(
	parameter int W = 8
);
	logic         valid;
	logic         ready;
	logic [W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[rtl/bcd_digit_serial_calculator_core_unit.sv]
// Channel  Dir  Payload bits
// in_ch    in   instruction[12:0], key_rows[52:13]
// out_ch   out  fetch_addr[10:0], cond_flag[11], r5_value[19:12], digit_valid[20],
//              digit_pos[24:21], digit_code[29:25], last[30]
// Each instruction is decoded when it is accepted. Digit-serial ALU work then handles one digit
// per cycle of the mask range (1 to 16), driven by one shared digit adder.
// DISP walks the 12 display positions, each producing one output beat.
// Reset clears the four registers, every bank and the stack at once. The block holds ready low
// until all beats of an item have been taken; a stalled output simply holds.
module bcd_digit_serial_calculator_core_unit #(
	parameter int STORE_BANK_DEPTH = bdsc_pkg::STORE_BANK_DEPTH_DEF,
	parameter int STACK_DEPTH = bdsc_pkg::STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	bdsc_stream_if.sink   in_ch,
	bdsc_stream_if.source out_ch
);
	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_ALU  = 3'd1;
	localparam logic [2:0] ST_DISP = 3'd2;
	localparam logic [2:0] ST_OUT  = 3'd3;
	localparam int BW = (STORE_BANK_DEPTH > 1) ? $clog2(STORE_BANK_DEPTH) : 1;

	logic [2:0]  state_q;
	logic [63:0] regs_q [4];
	logic [63:0] xb_q [STORE_BANK_DEPTH];
	logic [63:0] yb_q [STORE_BANK_DEPTH];
	logic [10:0] stk_q [STACK_DEPTH];
	logic [10:0] pc_q;
	logic [2:0]  bank_q;
	logic        hex_q;
	logic        cond_q;
	logic [7:0]  r5_q;
	logic [12:0] op_q;
	logic [3:0]  idx_q;
	logic        carry_q;
	logic [63:0] acc_q;
	logic [63:0] accb_q;
	logic [63:0] s2_q;
	logic [3:0]  lo_q;
	logic [3:0]  hi_q;
	logic        b16_q;
	logic        ovalid_q;
	logic        olast_q;
	logic        odv_q;
	logic [3:0]  opos_q;
	logic [4:0]  ocode_q;

	logic [12:0] iop;
	logic [39:0] ikeys;
	assign iop = in_ch.data[12:0];
	assign ikeys = in_ch.data[52:13];

	logic [BW-1:0] bk;
	always_comb begin
		bk = '0;
		for (int v = 0; v < 8; v++) begin
			if (bank_q == 3'(v)) bk = BW'(v % STORE_BANK_DEPTH);
		end
	end

	logic [7:0] key_r5;
	logic       key_hit;
	always_comb begin
		key_r5 = '0;
		key_hit = 1'b0;
		for (int p = 7; p >= 0; p--) begin
			if (ikeys[5*p +: 5] != 5'd0) begin
				key_hit = 1'b1;
				if (ikeys[5*p]) key_r5 = {4'd1, 4'(7 - p)};
				else if (ikeys[5*p+1]) key_r5 = {4'd2, 4'(7 - p)};
				else if (ikeys[5*p+2]) key_r5 = {4'd3, 4'(7 - p)};
				else if (ikeys[5*p+3]) key_r5 = {4'd4, 4'(7 - p)};
				else key_r5 = {4'd5, 4'(7 - p)};
			end
		end
	end

	logic [1:0] fj, fl;
	logic [2:0] fk;
	logic       fn;
	assign fj = op_q[7:6];
	assign fk = op_q[5:3];
	assign fl = op_q[2:1];
	assign fn = op_q[0];

	function automatic logic [3:0] dg(input logic [63:0] r, input logic [3:0] i);
		return r[{i, 2'b00} +: 4];
	endfunction

	logic [3:0] da, db, dsrc, dres;
	logic [5:0] sum;
	logic       cout;
	logic [4:0] basev;
	always_comb begin
		basev = b16_q ? 5'd16 : 5'd10;
		da = dg(acc_q, idx_q);
		db = dg(s2_q, idx_q);
		dsrc = 4'd0;
		dres = 4'd0;
		cout = 1'b0;
		sum = 6'd0;
		if (fl == 2'd3 && fn) begin
			sum = {2'b00, db} + {5'd0, carry_q};
			if (sum >= {1'b0, basev}) begin
				sum = sum - {1'b0, basev};
				cout = 1'b1;
			end
			dres = sum[3:0];
		end else if (fn) begin
			sum = {2'b00, da} - {2'b00, db} - {5'd0, carry_q};
			if (sum[5]) begin
				sum = sum + {1'b0, basev};
				cout = 1'b1;
			end
			dres = sum[3:0];
		end else begin
			sum = {2'b00, da} + {2'b00, db} + {5'd0, carry_q};
			if (sum >= {1'b0, basev}) begin
				sum = sum - {1'b0, basev};
				cout = 1'b1;
			end
			dres = sum[3:0];
		end
		dsrc = dres;
	end

	logic is_xchg, is_shift;
	assign is_xchg = (fl == 2'd3) && !fn;
	assign is_shift = (fl != 2'd3) && (fk == 3'd5);

	logic [3:0] dpos_idx;
	logic [3:0] dispa, dispb;
	logic [4:0] dcode;
	always_comb begin
		dpos_idx = 4'd11 - idx_q;
		dispa = dg(regs_q[0], dpos_idx);
		dispb = dg(regs_q[1], dpos_idx);
		if (dispb[3]) dcode = 5'h0F;
		else if (dispb[0]) dcode = 5'h0E;
		else dcode = {1'b0, dispa};
		if (dispb[1]) dcode[4] = 1'b1;
	end

	logic [63:0] acc_setr5;
	logic [3:0]  rlo;
	assign in_ch.ready = (state_q == ST_IDLE) && !ovalid_q;

	assign out_ch.valid = ovalid_q;
	assign out_ch.data = {olast_q, ocode_q, opos_q, odv_q, r5_q, cond_q, pc_q};

	logic [63:0] res_next;
	logic [63:0] accb_next;
	always_comb begin
		res_next = acc_q;
		accb_next = accb_q;
		if (is_xchg) begin
			res_next[{idx_q, 2'b00} +: 4] = dg(accb_q, idx_q);
			accb_next[{idx_q, 2'b00} +: 4] = dg(acc_q, idx_q);
		end else if (is_shift) begin
			if (!fn) res_next[{idx_q, 2'b00} +: 4] =
				(idx_q == lo_q) ? 4'd0 : dg(accb_q, idx_q - 4'd1);
			else res_next[{idx_q, 2'b00} +: 4] =
				(idx_q == hi_q) ? 4'd0 : dg(accb_q, idx_q + 4'd1);
		end else begin
			res_next[{idx_q, 2'b00} +: 4] = dsrc;
		end
		acc_setr5 = (fl == 2'd3 && fn) ? s2_q : res_next;
		rlo = lo_q;
	end

	logic [7:0] r5_fin;
	always_comb begin
		r5_fin = {4'd0, dg(acc_setr5, rlo)};
		if (lo_q < hi_q) r5_fin[7:4] = dg(acc_setr5, rlo + 4'd1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			for (int i = 0; i < 4; i++) regs_q[i] <= '0;
			for (int i = 0; i < STORE_BANK_DEPTH; i++) begin
				xb_q[i] <= '0;
				yb_q[i] <= '0;
			end
			for (int i = 0; i < STACK_DEPTH; i++) stk_q[i] <= '0;
			pc_q <= '0;
			bank_q <= '0;
			hex_q <= 1'b0;
			cond_q <= 1'b0;
			r5_q <= '0;
			ovalid_q <= 1'b0;
			olast_q <= 1'b0;
			odv_q <= 1'b0;
			opos_q <= '0;
			ocode_q <= '0;
			idx_q <= '0;
			carry_q <= 1'b0;
		end else begin
			if (ovalid_q && out_ch.ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid && in_ch.ready) begin
						logic [10:0] pcn;
						logic [63:0] s2;
						bdsc_pkg::range_t rg;
						logic [1:0] j, l;
						logic [2:0] k;
						pcn = pc_q + 11'd1;
						op_q <= iop;
						odv_q <= 1'b0;
						opos_q <= '0;
						ocode_q <= '0;
						olast_q <= 1'b1;
						j = iop[7:6];
						k = iop[5:3];
						l = iop[2:1];
						rg = bdsc_pkg::mask_range(iop[11:8]);
						pc_q <= pcn;
						state_q <= ST_OUT;
						if (iop[12]) begin
							if (iop[11]) begin
								if (cond_q == iop[10]) pc_q <= {pcn[10], iop[9:0]};
							end else begin
								for (int i = STACK_DEPTH - 1; i > 0; i--) stk_q[i] <= stk_q[i-1];
								stk_q[0] <= pcn;
								pc_q <= iop[10:0];
							end
							cond_q <= 1'b0;
						end else if (iop[11:8] == bdsc_pkg::MASK_FLAG && iop[5:4] != 2'd0) begin
							logic [3:0] v, bt;
							logic [3:0] d;
							d = {2'b11, iop[5:4]};
							v = dg(regs_q[j], d);
							bt = 4'd1 << iop[3:2];
							case (iop[1:0])
								2'd0: v = v | bt;
								2'd1: v = v & ~bt;
								2'd2: if ((v & bt) != 4'd0) cond_q <= 1'b1;
								default: v = v ^ bt;
							endcase
							regs_q[j][{d, 2'b00} +: 4] <= v;
						end else if (iop[11:8] == bdsc_pkg::MASK_MISC) begin
							case (iop[3:0])
								bdsc_pkg::MISC_LDY: regs_q[0] <= yb_q[bk];
								bdsc_pkg::MISC_BANK: bank_q <= iop[6:4];
								bdsc_pkg::MISC_BR5: pc_q <= {3'd0, r5_q};
								bdsc_pkg::MISC_RET: begin
									cond_q <= 1'b0;
									pc_q <= stk_q[0];
									for (int i = 0; i < STACK_DEPTH - 1; i++) stk_q[i] <= stk_q[i+1];
									stk_q[STACK_DEPTH-1] <= '0;
								end
								bdsc_pkg::MISC_STX: xb_q[bk] <= regs_q[0];
								bdsc_pkg::MISC_LDX: regs_q[0] <= xb_q[bk];
								bdsc_pkg::MISC_STY: yb_q[bk] <= regs_q[0];
								bdsc_pkg::MISC_DISP: begin
									cond_q <= key_hit;
									r5_q <= key_r5;
									idx_q <= '0;
									state_q <= ST_DISP;
								end
								bdsc_pkg::MISC_DEC: hex_q <= 1'b0;
								bdsc_pkg::MISC_HEX: hex_q <= 1'b1;
								bdsc_pkg::MISC_BANKR: bank_q <= r5_q[2:0];
								default: ;
							endcase
						end else begin
							s2 = '0;
							if (!k[2]) s2 = regs_q[k[1:0]];
							else if (k == 3'd4) s2[{rg.lo, 2'b00} +: 4] = 4'd1;
							else if (k == 3'd6) s2[{rg.lo, 2'b00} +: 4] = r5_q[3:0];
							else if (k == 3'd7) begin
								s2[{rg.lo, 2'b00} +: 4] = r5_q[3:0];
								if (rg.lo < 4'd15) s2[{rg.lo + 4'd1, 2'b00} +: 4] = r5_q[7:4];
							end
							s2_q <= s2;
							lo_q <= rg.lo;
							hi_q <= rg.hi;
							b16_q <= iop[11] | hex_q;
							idx_q <= rg.lo;
							carry_q <= 1'b0;
							if (l == 2'd3) begin
								if (!iop[0]) begin
									acc_q <= regs_q[0];
									accb_q <= regs_q[k[1:0]];
									if (j == 2'd0 && !k[2]) state_q <= ST_ALU;
								end else begin
									acc_q <= regs_q[j];
									if (k != 3'd5) state_q <= ST_ALU;
								end
							end else if (k == 3'd5) begin
								acc_q <= regs_q[j];
								accb_q <= regs_q[j];
								if (l != 2'd1) state_q <= ST_ALU;
							end else begin
								acc_q <= regs_q[j];
								accb_q <= (l == 2'd0) ? regs_q[j] : ((l == 2'd1) ? regs_q[k[1:0]] : 64'd0);
								if (l == 2'd0 || (l == 2'd1 && !k[2]) || (l == 2'd2 && k < 3'd5))
									state_q <= ST_ALU;
							end
						end
					end
				end
				ST_ALU: begin
					logic [63:0] wr;
					carry_q <= cout;
					if (!(fl != 2'd3 && fk != 3'd5) || is_xchg || is_shift || (fl == 2'd3)) begin
						acc_q <= res_next;
						accb_q <= accb_next;
					end else begin
						acc_q <= acc_q;
						accb_q[{idx_q, 2'b00} +: 4] <= dsrc;
					end
					if (idx_q == hi_q) begin
						state_q <= ST_OUT;
						if (!is_xchg && !is_shift && cout) cond_q <= 1'b1;
						if (is_xchg) begin
							regs_q[fk[1:0]] <= accb_next;
							regs_q[0] <= res_next;
							r5_q <= r5_fin;
						end else if (is_shift || fl == 2'd3) begin
							regs_q[fj] <= res_next;
							r5_q <= r5_fin;
						end else begin
							wr = accb_q;
							wr[{idx_q, 2'b00} +: 4] = dsrc;
							if (fl == 2'd0) regs_q[fj] <= wr;
							else if (fl == 2'd1) regs_q[fk[1:0]] <= wr;
							r5_q <= {(lo_q < hi_q) ? dg(wr, lo_q + 4'd1) : 4'd0, dg(wr, lo_q)};
						end
					end else begin
						idx_q <= idx_q + 4'd1;
					end
				end
				ST_DISP: begin
					if (!ovalid_q || out_ch.ready) begin
						ovalid_q <= 1'b1;
						odv_q <= 1'b1;
						opos_q <= idx_q;
						ocode_q <= dcode;
						olast_q <= (idx_q == 4'd11);
						if (idx_q == 4'd11) state_q <= ST_IDLE;
						idx_q <= idx_q + 4'd1;
					end
				end
				ST_OUT: begin
					ovalid_q <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

[dv/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

	typedef struct {
		logic [10:0] fetch_addr;
		logic        cond_flag;
		logic [7:0]  r5_value;
		logic        digit_valid;
		logic [3:0]  digit_pos;
		logic [4:0]  digit_code;
		logic        last;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	bdsc_stream_if #(.W(53)) in_ch ();
	bdsc_stream_if #(.W(31)) out_ch ();

	bcd_digit_serial_calculator_core_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [63:0] regs [4];
	logic [63:0] xbank [8];
	logic [63:0] ybank [8];
	logic [10:0] rstack [3];
	logic [10:0] pc;
	logic [2:0]  bsel;
	logic        hexm;
	logic        cond;
	logic [7:0]  r5;

	logic [52:0] pending_q [$];
	beat_t       expected_q [$];
	int          mismatches = 0;
	int          beats_seen = 0;
	int          disp_seen = 0;
	int          cycles = 0;
	bit          calm = 0;
	int          hold_off = 0;
	int          send_gap = 0;
	int          recv_gap = 0;

	function automatic logic [3:0] dig(logic [63:0] r, int i);
		return r[4*(i&15) +: 4];
	endfunction

	function automatic logic [63:0] put(logic [63:0] r, int i, logic [3:0] v);
		r[4*(i&15) +: 4] = v;
		return r;
	endfunction

	function automatic void load_r5(logic [63:0] v, int lo, int hi);
		r5 = {(lo < hi) ? dig(v, lo + 1) : 4'h0, dig(v, lo)};
	endfunction

	function automatic logic [63:0] digit_sum(logic [63:0] init, logic [63:0] a,
			logic [63:0] b, int lo, int hi, int base, bit sub);
		int c = 0;
		int r;
		for (int i = lo; i <= hi; i++) begin
			if (sub) begin
				r = int'(dig(a, i)) - int'(dig(b, i)) - c;
				if (r < 0) begin
					r += base; c = 1;
				end else c = 0;
			end else begin
				r = int'(dig(a, i)) + int'(dig(b, i)) + c;
				if (r >= base) begin
					r -= base; c = 1;
				end else c = 0;
			end
			init = put(init, i, r[3:0]);
		end
		if (c) cond = 1'b1;
		load_r5(init, lo, hi);
		return init;
	endfunction

	function automatic void run_alu(logic [12:0] op);
		logic [3:0] m = op[11:8];
		int j = op[7:6];
		int k = op[5:3];
		int l = op[2:1];
		bit n = op[0];
		bdsc_pkg::range_t rg = bdsc_pkg::mask_range(m);
		int lo = rg.lo;
		int hi = rg.hi;
		int base = (m >= 8 || hexm) ? 16 : 10;
		logic [63:0] s2 = '0;
		logic [63:0] v;
		logic [63:0] a;
		logic [63:0] b;
		logic [3:0] t;
		int c;
		int r;
		if (k < 4) s2 = regs[k];
		else if (k == 4) s2 = put('0, lo, 4'h1);
		else if (k == 6) s2 = put('0, lo, r5[3:0]);
		else if (k == 7) begin
			s2 = put('0, lo, r5[3:0]);
			if (lo < 15) s2 = put(s2, lo + 1, r5[7:4]);
		end
		if (l == 3) begin
			if (!n) begin
				if (j == 0 && k < 4) begin
					a = regs[0]; b = regs[k];
					for (int i = lo; i <= hi; i++) begin
						t = dig(a, i);
						a = put(a, i, dig(b, i));
						b = put(b, i, t);
					end
					regs[k] = b; regs[0] = a;
					load_r5(regs[0], lo, hi);
				end
			end else if (k != 5) begin
				c = 0;
				v = regs[j];
				for (int i = lo; i <= hi; i++) begin
					r = int'(dig(s2, i)) + c;
					if (r >= base) begin
						r -= base; c = 1;
					end else c = 0;
					v = put(v, i, r[3:0]);
				end
				regs[j] = v;
				if (c) cond = 1'b1;
				load_r5(s2, lo, hi);
			end
			return;
		end
		if (k == 5) begin
			if (l == 1) return;
			v = regs[j];
			if (!n) begin
				for (int i = hi; i > lo; i--) v = put(v, i, dig(regs[j], i - 1));
				v = put(v, lo, 4'h0);
			end else begin
				for (int i = lo; i < hi; i++) v = put(v, i, dig(regs[j], i + 1));
				v = put(v, hi, 4'h0);
			end
			regs[j] = v;
			load_r5(v, lo, hi);
			return;
		end
		if (l == 0) regs[j] = digit_sum(regs[j], regs[j], s2, lo, hi, base, n);
		else if (l == 1) begin
			if (k < 4) regs[k] = digit_sum(regs[k], regs[j], s2, lo, hi, base, n);
		end else if (k < 5) void'(digit_sum('0, regs[j], s2, lo, hi, base, n));
	endfunction

	function automatic void execute(logic [12:0] op, logic [39:0] keys);
		logic [4:0] codes [12];
		bit disp = 0;
		int d;
		logic [3:0] bitm;
		logic [3:0] v;
		logic [3:0] a;
		logic [3:0] b;
		logic [4:0] cc;
		logic [4:0] kc;
		beat_t e;
		pc = pc + 11'd1;
		if (op[12]) begin
			if (op[11]) begin
				if (cond == op[10]) pc = {pc[10], op[9:0]};
			end else begin
				rstack[2] = rstack[1]; rstack[1] = rstack[0]; rstack[0] = pc;
				pc = op[10:0];
			end
			cond = 1'b0;
		end else if (op[11:8] == bdsc_pkg::MASK_FLAG && op[5:4] != 2'd0) begin
			d = op[5:4] + 12;
			bitm = 4'h1 << op[3:2];
			v = dig(regs[op[7:6]], d);
			case (op[1:0])
				2'd0: v |= bitm;
				2'd1: v &= ~bitm;
				2'd2: if (|(v & bitm)) cond = 1'b1;
				default: v ^= bitm;
			endcase
			regs[op[7:6]] = put(regs[op[7:6]], d, v);
		end else if (op[11:8] == bdsc_pkg::MASK_MISC) begin
			case (op[3:0])
				bdsc_pkg::MISC_LDY: regs[0] = ybank[bsel];
				bdsc_pkg::MISC_BANK: bsel = op[6:4];
				bdsc_pkg::MISC_BR5: pc = {3'b0, r5};
				bdsc_pkg::MISC_RET: begin
					cond = 1'b0; pc = rstack[0];
					rstack[0] = rstack[1]; rstack[1] = rstack[2]; rstack[2] = '0;
				end
				bdsc_pkg::MISC_STX: xbank[bsel] = regs[0];
				bdsc_pkg::MISC_LDX: regs[0] = xbank[bsel];
				bdsc_pkg::MISC_STY: ybank[bsel] = regs[0];
				bdsc_pkg::MISC_DISP: begin
					disp = 1; cond = 1'b0; r5 = '0;
					for (int i = 11; i >= 0; i--) begin
						a = dig(regs[0], i);
						b = dig(regs[1], i);
						if (b[3]) cc = 5'hF;
						else if (b[0]) cc = 5'hE;
						else cc = {1'b0, a};
						if (b[1]) cc[4] = 1'b1;
						codes[11 - i] = cc;
						if (i < 8) begin
							kc = keys[5*i +: 5];
							for (int col = 0; col < 5; col++) begin
								if (kc[col]) begin
									r5 = {col[3:0] + 4'd1, 1'b0, 3'(7 - i)};
									cond = 1'b1;
									break;
								end
							end
						end
					end
				end
				bdsc_pkg::MISC_DEC: hexm = 1'b0;
				bdsc_pkg::MISC_HEX: hexm = 1'b1;
				bdsc_pkg::MISC_BANKR: bsel = r5[2:0];
				default: ;
			endcase
		end else run_alu(op);
		for (int q = 0; q < (disp ? 12 : 1); q++) begin
			e.fetch_addr = pc;
			e.cond_flag = cond;
			e.r5_value = r5;
			e.digit_valid = disp;
			e.digit_pos = disp ? 4'(q) : 4'd0;
			e.digit_code = disp ? codes[q] : 5'd0;
			e.last = disp ? (q == 11) : 1'b1;
			expected_q.push_back(e);
		end
	endfunction

	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				execute(in_ch.data[12:0], in_ch.data[52:13]);
				void'(pending_q.pop_front());
			end
			if (send_gap > 0) begin
				send_gap <= send_gap - 1;
				in_ch.valid <= 1'b0;
			end else if (!calm && !(in_ch.valid && !in_ch.ready)
					&& $urandom_range(0, 15) == 0) begin
				send_gap <= $urandom_range(1, 19);
				in_ch.valid <= 1'b0;
			end else if (pending_q.size() > 0) begin
				in_ch.valid <= 1'b1;
				in_ch.data <= pending_q[0];
			end else begin
				in_ch.valid <= 1'b0;
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			out_ch.ready <= 1'b0;
		end else if (recv_gap > 0) begin
			recv_gap <= recv_gap - 1;
			out_ch.ready <= 1'b0;
		end else if (!calm && $urandom_range(0, 11) == 0) begin
			recv_gap <= $urandom_range(1, 19);
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		beat_t e;
		logic [30:0] d;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			d = out_ch.data;
			beats_seen++;
			if (d[20]) disp_seen++;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected beat %h", d);
			end else begin
				e = expected_q.pop_front();
				if (d[10:0] !== e.fetch_addr || d[11] !== e.cond_flag
						|| d[19:12] !== e.r5_value || d[20] !== e.digit_valid
						|| d[24:21] !== e.digit_pos || d[29:25] !== e.digit_code
						|| d[30] !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: got pc=%h c=%b r5=%h dv=%b pos=%0d code=%h last=%b,%s",
							d[10:0], d[11], d[19:12], d[20], d[24:21], d[29:25], d[30],
							$sformatf(" want pc=%h c=%b r5=%h dv=%b pos=%0d code=%h last=%b",
							e.fetch_addr, e.cond_flag, e.r5_value, e.digit_valid,
							e.digit_pos, e.digit_code, e.last));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > 400000) begin
			$display("timeout with %0d beats outstanding", expected_q.size());
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic logic [39:0] rand_keys();
		logic [39:0] k = 40'({$urandom, $urandom});
		case ($urandom_range(0, 3))
			0: k = '0;
			1: k = 40'h1 << $urandom_range(0, 39);
			default: ;
		endcase
		return k;
	endfunction

	function automatic logic [12:0] rand_op();
		logic [12:0] op = 13'($urandom);
		case ($urandom_range(0, 9))
			0: op = {1'b0, bdsc_pkg::MASK_MISC, 4'($urandom), 4'($urandom_range(0, 15))};
			1: op = {1'b0, bdsc_pkg::MASK_MISC, 4'($urandom), bdsc_pkg::MISC_DISP};
			2: op = {1'b0, bdsc_pkg::MASK_FLAG, 8'($urandom)};
			3: op = {2'b11, 11'($urandom)};
			4: op = {2'b10, 11'($urandom)};
			5: op = {1'b0, bdsc_pkg::MASK_MISC, 4'($urandom), bdsc_pkg::MISC_RET};
			default: op = {1'b0, 12'($urandom)};
		endcase
		return op;
	endfunction

	task automatic add_item(logic [12:0] op, logic [39:0] keys);
		pending_q.push_back({keys, op});
	endtask

	initial begin
		in_ch.valid = 1'b0;
		in_ch.data = '0;
		out_ch.ready = 1'b0;
		foreach (regs[i]) regs[i] = '0;
		foreach (xbank[i]) begin
			xbank[i] = '0; ybank[i] = '0;
		end
		foreach (rstack[i]) rstack[i] = '0;
		pc = '0; bsel = '0; hexm = 1'b0; cond = 1'b0; r5 = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		add_item({1'b0, 4'h1, 2'd0, 3'd4, 2'd0, 1'b0}, '0);
		add_item({1'b0, 4'h1, 2'd1, 3'd0, 2'd0, 1'b1}, '0);
		add_item({1'b0, 4'h7, 2'd0, 3'd1, 2'd3, 1'b0}, '0);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, bdsc_pkg::MISC_HEX}, '0);
		add_item({1'b0, 4'h6, 2'd2, 3'd7, 2'd3, 1'b1}, '1);
		add_item({1'b0, 4'hB, 2'd3, 3'd6, 2'd0, 1'b0}, '0);
		add_item({1'b0, bdsc_pkg::MASK_FLAG, 2'd1, 2'd0, 2'd1, 2'd0}, '0);
		add_item({1'b0, bdsc_pkg::MASK_FLAG, 2'd1, 2'd3, 2'd3, 2'd2}, '0);
		add_item({1'b0, bdsc_pkg::MASK_FLAG, 2'd0, 2'd2, 2'd0, 2'd3}, '0);
		add_item({1'b0, bdsc_pkg::MASK_FLAG, 2'd2, 2'd1, 2'd1, 2'd1}, '0);
		add_item({1'b0, 4'h3, 2'd1, 3'd5, 2'd0, 1'b0}, '0);
		add_item({1'b0, 4'h3, 2'd1, 3'd5, 2'd0, 1'b1}, '0);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, bdsc_pkg::MISC_DISP}, 40'h80_0000_0001);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, bdsc_pkg::MISC_DISP}, 40'hFF_FFFF_FFFF);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h7, bdsc_pkg::MISC_BANK}, '0);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, bdsc_pkg::MISC_STX}, '0);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, bdsc_pkg::MISC_STY}, '0);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, bdsc_pkg::MISC_LDX}, '0);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, bdsc_pkg::MISC_LDY}, '0);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, bdsc_pkg::MISC_BANKR}, '0);
		add_item({2'b10, 11'h7FF}, '0);
		add_item({2'b10, 11'h000}, '0);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, bdsc_pkg::MISC_RET}, '0);
		add_item({2'b11, 1'b0, 10'h3FF}, '0);
		add_item({2'b11, 1'b1, 10'h155}, '0);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, bdsc_pkg::MISC_BR5}, '0);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, bdsc_pkg::MISC_DEC}, '0);
		add_item({1'b0, bdsc_pkg::MASK_MISC, 4'h0, 4'hF}, '0);

		wait (pending_q.size() == 0);
		hold_off = 300;
		for (int i = 0; i < 20; i++) add_item(rand_op(), rand_keys());
		for (int i = 0; i < 300; i++) add_item(rand_op(), rand_keys());
		wait (pending_q.size() < 40);
		calm = 1;
		for (int i = 0; i < 40; i++) add_item(rand_op(), rand_keys());
		wait (pending_q.size() == 0);
		wait (expected_q.size() == 0);
		repeat (40) @(posedge clk);
		$display("Ran directed and random instructions: %0d result beats, %0d display digits.",
			beats_seen, disp_seen);
		if (mismatches == 0 && expected_q.size() == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
